>>> sv/bmu_pkg.sv
// bmu_pkg: shared types and codes for the breakpoint match unit
`timescale 1ns / 1ps
package bmu_pkg;

  localparam int DEF_MAX_BREAKPOINTS = 16;
  localparam int DEF_FILE_ID_BITS    = 8;
  localparam int DEF_LINE_BITS       = 20;

  localparam logic [1:0] MODE_TRACE = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_DEL   = 2'd2;
  localparam logic [1:0] MODE_STEP  = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_DELETED   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [2:0] OP_DROP  = 3'd0;
  localparam logic [2:0] OP_TRACE = 3'd1;
  localparam logic [2:0] OP_ADD   = 3'd2;
  localparam logic [2:0] OP_DEL   = 3'd3;
  localparam logic [2:0] OP_STEP  = 3'd4;

  localparam logic [15:0] IDENT_LAST = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic        has_location;
    logic [7:0]  file_id;
    logic [19:0] line_number;
    logic [15:0] ignore_count;
    logic        make_temporary;
    logic [15:0] target_id;
  } in_item_t;

  typedef struct packed {
    logic        break_now;
    logic [1:0]  status;
    logic [15:0] assigned_id;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  op;
    logic        has_loc;
    logic [7:0]  file_id;
    logic [19:0] line_number;
    logic [15:0] ignore_count;
    logic        temp;
    logic [15:0] target_id;
  } q_item_t;

endpackage

>>> sv/bmu_front.sv
// bmu_front: accepts items, filters repeated trace locations, two-entry queue
`timescale 1ns / 1ps
module bmu_front import bmu_pkg::*; #(
  parameter int FILE_ID_BITS = DEF_FILE_ID_BITS,
  parameter int LINE_BITS    = DEF_LINE_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_item,
  output logic     q_valid,
  output q_item_t  q_head,
  input  logic     q_pop
);

  localparam int FS = (FILE_ID_BITS < 8) ? FILE_ID_BITS : 8;
  localparam int LS = (LINE_BITS < 20) ? LINE_BITS : 20;

  logic          last_valid_r, last_valid_nxt;
  logic [FS-1:0] last_file_r, last_file_nxt;
  logic [LS-1:0] last_line_r, last_line_nxt;
  q_item_t       q_mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          accept, drop, same_loc;
  q_item_t       cls;

  assign busy    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = q_mem_r[rd_ptr_r];
  assign accept  = start && !busy;

  assign same_loc = (last_file_r == in_item.file_id[FS-1:0]) &&
                    (last_line_r == in_item.line_number[LS-1:0]);
  assign drop = (!in_item.has_location && !last_valid_r) ||
                (in_item.has_location && last_valid_r && same_loc);

  always_comb begin
    cls.has_loc      = in_item.has_location;
    cls.file_id      = in_item.file_id;
    cls.line_number  = in_item.line_number;
    cls.ignore_count = in_item.ignore_count;
    cls.temp         = in_item.make_temporary;
    cls.target_id    = in_item.target_id;
    unique case (in_item.mode)
      MODE_TRACE: cls.op = drop ? OP_DROP : OP_TRACE;
      MODE_ADD:   cls.op = OP_ADD;
      MODE_DEL:   cls.op = OP_DEL;
      default:    cls.op = OP_STEP;
    endcase
  end

  always_comb begin
    last_valid_nxt = last_valid_r;
    last_file_nxt  = last_file_r;
    last_line_nxt  = last_line_r;
    if (accept && in_item.mode == MODE_TRACE && !drop) begin
      last_valid_nxt = in_item.has_location;
      if (in_item.has_location) begin
        last_file_nxt = in_item.file_id[FS-1:0];
        last_line_nxt = in_item.line_number[LS-1:0];
      end
    end
    cnt_nxt = cnt_r + {1'b0, accept} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_valid_r <= 1'b0;
      last_file_r  <= '0;
      last_line_r  <= '0;
      wr_ptr_r     <= 1'b0;
      rd_ptr_r     <= 1'b0;
      cnt_r        <= 2'd0;
    end else begin
      last_valid_r <= last_valid_nxt;
      last_file_r  <= last_file_nxt;
      last_line_r  <= last_line_nxt;
      cnt_r        <= cnt_nxt;
      if (accept) begin
        q_mem_r[wr_ptr_r] <= cls;
        wr_ptr_r          <= !wr_ptr_r;
      end
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
    end
  end

endmodule

>>> sv/bmu_back.sv
// bmu_back: breakpoint table, scan sequencer and result register
`timescale 1ns / 1ps
module bmu_back import bmu_pkg::*; #(
  parameter int MAX_BREAKPOINTS = DEF_MAX_BREAKPOINTS,
  parameter int FILE_ID_BITS    = DEF_FILE_ID_BITS,
  parameter int LINE_BITS       = DEF_LINE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_item_t   q_head,
  output logic      q_pop,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int N     = MAX_BREAKPOINTS;
  localparam int FS    = (FILE_ID_BITS < 8) ? FILE_ID_BITS : 8;
  localparam int LS    = (LINE_BITS < 20) ? LINE_BITS : 20;
  localparam int IDX_W = (N > 1) ? $clog2(N) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(N - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  localparam out_item_t OUT_PLAIN = '{break_now: 1'b0, status: ST_DONE, assigned_id: 16'd0};
  localparam out_item_t OUT_BREAK = '{break_now: 1'b1, status: ST_DONE, assigned_id: 16'd0};
  localparam out_item_t OUT_FULL  = '{break_now: 1'b0, status: ST_FULL, assigned_id: 16'd0};
  localparam out_item_t OUT_DEL   = '{break_now: 1'b0, status: ST_DELETED,
                                      assigned_id: 16'd0};
  localparam out_item_t OUT_MISS  = '{break_now: 1'b0, status: ST_NOT_FOUND,
                                      assigned_id: 16'd0};

  logic [1:0]       state_r;
  q_item_t          cur_r;
  logic [IDX_W-1:0] idx_r;
  logic [15:0]      next_ident_r;
  logic             step_r;
  logic             out_valid_r;
  out_item_t        out_r;

  logic [N-1:0]  valid_r;
  logic [FS-1:0] file_r   [N];
  logic [LS-1:0] line_r   [N];
  logic [15:0]   ident_r  [N];
  logic [15:0]   skip_r   [N];
  logic [15:0]   reload_r [N];
  logic          temp_r   [N];

  logic is_trace, hit, at_end;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign is_trace = (cur_r.op == OP_TRACE);
  assign hit = valid_r[idx_r] && (is_trace ?
               (file_r[idx_r] == cur_r.file_id[FS-1:0] &&
                line_r[idx_r] == cur_r.line_number[LS-1:0]) :
               (ident_r[idx_r] == cur_r.target_id));
  assign at_end = (idx_r == IDX_LAST) || !valid_r[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      next_ident_r <= 16'd0;
      step_r       <= 1'b1;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          out_valid_r <= 1'b0;
          if (q_valid) begin
            cur_r   <= q_head;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          idx_r <= '0;
          unique case (cur_r.op)
            OP_STEP: begin
              step_r      <= 1'b1;
              out_r       <= OUT_PLAIN;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
            OP_ADD: begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
              if (valid_r[N-1] || next_ident_r == IDENT_LAST) begin
                out_r <= OUT_FULL;
              end else begin
                for (int j = N - 1; j > 0; j--) begin
                  valid_r[j]  <= valid_r[j-1];
                  file_r[j]   <= file_r[j-1];
                  line_r[j]   <= line_r[j-1];
                  ident_r[j]  <= ident_r[j-1];
                  skip_r[j]   <= skip_r[j-1];
                  reload_r[j] <= reload_r[j-1];
                  temp_r[j]   <= temp_r[j-1];
                end
                valid_r[0]   <= 1'b1;
                file_r[0]    <= cur_r.file_id[FS-1:0];
                line_r[0]    <= cur_r.line_number[LS-1:0];
                ident_r[0]   <= next_ident_r + 16'd1;
                skip_r[0]    <= cur_r.ignore_count;
                reload_r[0]  <= cur_r.ignore_count;
                temp_r[0]    <= cur_r.temp;
                next_ident_r <= next_ident_r + 16'd1;
                out_r <= '{break_now: 1'b0, status: ST_DONE,
                           assigned_id: next_ident_r + 16'd1};
              end
            end
            OP_TRACE: begin
              if (step_r) begin
                step_r      <= 1'b0;
                out_r       <= OUT_BREAK;
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end else if (!cur_r.has_loc) begin
                out_r       <= OUT_PLAIN;
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end else begin
                out_valid_r <= 1'b0;
                state_r     <= S_SCAN;
              end
            end
            OP_DEL: begin
              out_valid_r <= 1'b0;
              state_r     <= S_SCAN;
            end
            default: begin
              out_r       <= OUT_PLAIN;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          endcase
        end
        S_SCAN: begin
          if (hit && is_trace && skip_r[idx_r] != 16'd0) begin
            skip_r[idx_r] <= skip_r[idx_r] - 16'd1;
            if (at_end) begin
              out_r       <= OUT_PLAIN;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              out_valid_r <= 1'b0;
              idx_r       <= idx_r + 1'b1;
            end
          end else if (hit) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (is_trace) begin
              out_r <= OUT_BREAK;
            end else begin
              out_r <= OUT_DEL;
            end
            if (!is_trace || temp_r[idx_r]) begin
              for (int j = 0; j < N - 1; j++) begin
                if (IDX_W'(j) >= idx_r) begin
                  valid_r[j]  <= valid_r[j+1];
                  file_r[j]   <= file_r[j+1];
                  line_r[j]   <= line_r[j+1];
                  ident_r[j]  <= ident_r[j+1];
                  skip_r[j]   <= skip_r[j+1];
                  reload_r[j] <= reload_r[j+1];
                  temp_r[j]   <= temp_r[j+1];
                end
              end
              valid_r[N-1] <= 1'b0;
            end else begin
              skip_r[idx_r] <= reload_r[idx_r];
            end
          end else if (at_end) begin
            out_r       <= is_trace ? OUT_PLAIN : OUT_MISS;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            out_valid_r <= 1'b0;
            idx_r       <= idx_r + 1'b1;
          end
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");

  a_id_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.assigned_id != 16'd0) |->
      (out_item.status == ST_DONE && !out_item.break_now))
    else $error("assigned id with wrong status");

  a_ident_rises: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> next_ident_r >= $past(next_ident_r))
    else $error("id counter went back");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == S_EXEC) else $error("pop outside idle");

endmodule

>>> sv/breakpoint_match_unit_core.sv
// breakpoint_match_unit_core: top level of the breakpoint match unit
// channel   ports                        handshake
// input     start, busy, in_item         taken when start && !busy
// result    out_valid, out_item          one-cycle strobe, always taken
// drop, step and add items go from queue head through S_IDLE and S_EXEC to
// the result register; delete items and located trace items with no step
// pending then scan in S_SCAN, one entry per cycle, up to MAX_BREAKPOINTS
// the two-entry queue keeps accepting while the back end scans, until full
// reset (rst_n low, synchronous) empties the table and sets the step flag
`timescale 1ns / 1ps
module breakpoint_match_unit_core import bmu_pkg::*; #(
  parameter int MAX_BREAKPOINTS = DEF_MAX_BREAKPOINTS,
  parameter int FILE_ID_BITS    = DEF_FILE_ID_BITS,
  parameter int LINE_BITS       = DEF_LINE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic    q_valid, q_pop;
  q_item_t q_head;

  bmu_front #(
    .FILE_ID_BITS(FILE_ID_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_item(in_item),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  bmu_back #(
    .MAX_BREAKPOINTS(MAX_BREAKPOINTS),
    .FILE_ID_BITS   (FILE_ID_BITS),
    .LINE_BITS      (LINE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule
